FILE: rtl/tkog_pkg.sv
// shared types, constants and helpers for the two-kind occupancy grid
`default_nettype none
package tkog_pkg;
  localparam int MAX_SIDE   = 64;
  localparam int ID_BITS    = 16;
  localparam int SIDE_BITS  = $clog2(MAX_SIDE);
  localparam int ADDR_BITS  = 2 * SIDE_BITS;
  localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W     = ID_BITS + 1;
  localparam int CFG_W      = 7;
  localparam int COORD_W    = 10;
  localparam int OUT_ID_W   = 16;
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_PLACE = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_MOVE  = 2'd3
  } mode_t;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_RDWAIT,
    ST_MNEW,
    ST_RESP
  } state_t;

  function automatic logic on_grid(input logic [COORD_W-1:0] c,
                                   input logic [CFG_W-1:0] lim);
    return !c[COORD_W-1] &&
           (c[COORD_W-2:0] < {{(COORD_W-1-CFG_W){1'b0}}, lim});
  endfunction

  function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
    return {y[SIDE_BITS-1:0], x[SIDE_BITS-1:0]};
  endfunction

  function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    return (v > CFG_W'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : v;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/tkog_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module tkog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/two_kind_occupancy_grid_top.sv
// two-kind occupancy grid: human and predator cell tables in block memories
// One item is handled at a time. A place, or a move before the first clear, goes
// from the execute state to the response state; a query passes a read wait state
// first, a move (read, clear old cell, write new cell through the single write
// port of each table) the read wait and new-cell states, and a clear the clear
// state, which writes every one of the 4096 cells of both tables, one per cycle.
// The result is registered on leaving the response state, and the next input
// transfer can be taken in the same cycle as that result is first offered. The
// result waits in an output register so the next item can start before the
// result is taken; an item whose result is ready waits while the previous result
// has not been taken. The grid size registers take effect at the next clear;
// before the first clear, queries report empty and place and move do nothing.
`default_nettype none
module two_kind_occupancy_grid_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_addr,
  input  wire logic [tkog_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // entity_id, entity_dead, cell_x, cell_y, old_x, old_y, zero fill
  input  wire logic [tkog_pkg::IN_DATA_W-1:0]      s_tdata,
  // mode, entity_kind
  input  wire logic [tkog_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // human_present, human_id, predator_present, predator_id, cell_blocked,
  // is_built, zero fill
  output logic      [tkog_pkg::OUT_DATA_W-1:0]     m_tdata
);
  localparam int CW = tkog_pkg::COORD_W;
  localparam int AW = tkog_pkg::ADDR_BITS;
  localparam int DW = tkog_pkg::CELL_W;
  localparam int IW = tkog_pkg::ID_BITS;
  localparam int OW = tkog_pkg::OUT_ID_W;

  tkog_pkg::state_t state, state_next;

  logic [tkog_pkg::CFG_W-1:0] grid_width, grid_height, live_w, live_h;
  logic                       built;
  logic [AW-1:0]              clr_cnt;

  tkog_pkg::mode_t item_mode;
  logic            item_kind, item_dead;
  logic [IW-1:0]   item_id;
  logic [CW-1:0]   item_cx, item_cy, item_ox, item_oy;

  logic          res_hp, res_pp;
  logic [IW-1:0] res_hid, res_pid;

  logic          new_ok, old_ok;
  logic [AW-1:0] new_idx, old_idx, rd_addr, wr_addr;
  logic          h_we, p_we, old_match;
  logic [DW-1:0] wr_data, h_rd, p_rd, kind_rd;
  logic          out_free;

  assign new_ok   = built && tkog_pkg::on_grid(item_cx, live_w)
                          && tkog_pkg::on_grid(item_cy, live_h);
  assign old_ok   = built && tkog_pkg::on_grid(item_ox, live_w)
                          && tkog_pkg::on_grid(item_oy, live_h);
  assign new_idx  = tkog_pkg::cell_addr(item_cx, item_cy);
  assign old_idx  = tkog_pkg::cell_addr(item_ox, item_oy);
  assign rd_addr  = (item_mode == tkog_pkg::MODE_MOVE) ? old_idx : new_idx;
  assign kind_rd  = item_kind ? p_rd : h_rd;
  assign old_match = old_ok && kind_rd[DW-1] && (kind_rd[IW-1:0] == item_id);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == tkog_pkg::ST_IDLE);

  tkog_ram #(.WIDTH(DW), .DEPTH(tkog_pkg::CELL_COUNT)) u_human_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (h_rd)
  );

  tkog_ram #(.WIDTH(DW), .DEPTH(tkog_pkg::CELL_COUNT)) u_predator_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (p_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      tkog_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = tkog_pkg::ST_EXEC;
        end
      end
      tkog_pkg::ST_EXEC: begin
        case (item_mode)
          tkog_pkg::MODE_CLEAR: state_next = tkog_pkg::ST_CLEAR;
          tkog_pkg::MODE_PLACE: state_next = tkog_pkg::ST_RESP;
          tkog_pkg::MODE_QUERY: state_next = tkog_pkg::ST_RDWAIT;
          tkog_pkg::MODE_MOVE:
            state_next = built ? tkog_pkg::ST_RDWAIT : tkog_pkg::ST_RESP;
          default: state_next = tkog_pkg::ST_RESP;
        endcase
      end
      tkog_pkg::ST_CLEAR: begin
        if (&clr_cnt) begin
          state_next = tkog_pkg::ST_RESP;
        end
      end
      tkog_pkg::ST_RDWAIT: begin
        state_next = (item_mode == tkog_pkg::MODE_MOVE) ? tkog_pkg::ST_MNEW
                                                         : tkog_pkg::ST_RESP;
      end
      tkog_pkg::ST_MNEW: state_next = tkog_pkg::ST_RESP;
      tkog_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = tkog_pkg::ST_IDLE;
        end
      end
      default: state_next = tkog_pkg::ST_IDLE;
    endcase
  end

  // memory write controls
  always_comb begin
    h_we    = 1'b0;
    p_we    = 1'b0;
    wr_addr = new_idx;
    wr_data = {1'b1, item_id};
    case (state)
      tkog_pkg::ST_CLEAR: begin
        h_we    = 1'b1;
        p_we    = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
      end
      tkog_pkg::ST_EXEC: begin
        if (item_mode == tkog_pkg::MODE_PLACE && !item_dead && new_ok) begin
          h_we = !item_kind;
          p_we = item_kind;
        end
      end
      tkog_pkg::ST_RDWAIT: begin
        wr_addr = old_idx;
        wr_data = '0;
        if (item_mode == tkog_pkg::MODE_MOVE && old_match) begin
          h_we = !item_kind;
          p_we = item_kind;
        end
      end
      tkog_pkg::ST_MNEW: begin
        if (new_ok) begin
          h_we = !item_kind;
          p_we = item_kind;
        end
      end
      default: begin
        h_we = 1'b0;
        p_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tkog_pkg::ST_IDLE;
      grid_width  <= tkog_pkg::CFG_W'(1);
      grid_height <= tkog_pkg::CFG_W'(1);
      live_w      <= '0;
      live_h      <= '0;
      built       <= 1'b0;
      clr_cnt     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (tkog_pkg::reg_idx_t'(cfg_addr))
          tkog_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_wdata;
          tkog_pkg::REG_GRID_HEIGHT: grid_height <= cfg_wdata;
          default: grid_width <= grid_width;
        endcase
      end
      if (state == tkog_pkg::ST_EXEC) begin
        clr_cnt <= '0;
      end else if (state == tkog_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (&clr_cnt) begin
          live_w <= tkog_pkg::clamp_side(grid_width);
          live_h <= tkog_pkg::clamp_side(grid_height);
          built  <= 1'b1;
        end
      end
      if (state == tkog_pkg::ST_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item capture, query result and output payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_mode <= tkog_pkg::mode_t'(s_tuser[1:0]);
      item_kind <= s_tuser[2];
      item_id   <= s_tdata[IW-1:0];
      item_dead <= s_tdata[16];
      item_cx   <= s_tdata[26:17];
      item_cy   <= s_tdata[36:27];
      item_ox   <= s_tdata[46:37];
      item_oy   <= s_tdata[56:47];
    end
    if (state == tkog_pkg::ST_EXEC) begin
      res_hp  <= 1'b0;
      res_hid <= '0;
      res_pp  <= 1'b0;
      res_pid <= '0;
    end else if (state == tkog_pkg::ST_RDWAIT && item_mode == tkog_pkg::MODE_QUERY &&
                 new_ok) begin
      res_hp  <= h_rd[DW-1];
      res_hid <= h_rd[DW-1] ? h_rd[IW-1:0] : '0;
      res_pp  <= p_rd[DW-1];
      res_pid <= p_rd[DW-1] ? p_rd[IW-1:0] : '0;
    end
    if (state == tkog_pkg::ST_RESP && out_free) begin
      m_tdata <= {4'b0, built, res_hp | res_pp, res_pid[OW-1:0], res_pp,
                  res_hid[OW-1:0], res_hp};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tkog_checker.sv
// port-level checks for the two-kind occupancy grid, bound to the top level
`default_nettype none
module tkog_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [tkog_pkg::OUT_DATA_W-1:0]     m_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  a_blocked: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[34] == (m_tdata[0] | m_tdata[17]))
    else $error("cell_blocked disagrees with presence bits");

  a_absent_ids: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] || m_tdata[16:1] == 16'd0) &&
                 (m_tdata[17] || m_tdata[33:18] == 16'd0))
    else $error("id reported for an empty table");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in work");
endmodule

bind two_kind_occupancy_grid_top tkog_checker u_tkog_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
